/* hdl/msb_first_bit_packer_unit_macros.svh */
// assertion macros used by the bit packer back end
`ifndef MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MFBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MFBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mfbp_pkg.sv */
// types and constants of the msb-first bit packer
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int CNT_W       = 6;
  localparam int PEND_W      = 7;
  localparam int PCNT_W      = 3;
  localparam int ACC_W       = PEND_W + FIELD_WIDTH;
  localparam int MAX_BYTES   = 4;
  localparam int NB_W        = 3;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FLUSH = 1'b1
  } mfbp_cmd_t;

  typedef struct packed {
    mfbp_cmd_t             command;
    logic [31:0]           value;
    logic [CNT_W-1:0]      bit_count;
  } mfbp_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] used_bits;
    logic       last;
  } mfbp_out_t;

  // one queued job: right-aligned bytes, highest byte goes first
  typedef struct packed {
    logic [31:0]      word;
    logic [NB_W-1:0]  nbytes;
    logic [3:0]       tail_used;
  } mfbp_entry_t;

endpackage

/* hdl/mfbp_front.sv */
// front end: takes items, tracks the pending partial byte, queues byte jobs
`timescale 1ns / 1ps

module mfbp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  mfbp_pkg::mfbp_in_t   in_data,
  input  logic                 q_full,
  output logic                 wr_en,
  output mfbp_pkg::mfbp_entry_t wr_entry
);
  import mfbp_pkg::*;

  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [PCNT_W-1:0] pcount_r, pcount_nxt;

  logic              accept;
  logic [CNT_W-1:0]  cnt_sat;
  logic [32:0]       mask_w;
  logic [31:0]       vmask;
  logic [ACC_W-1:0]  combined;
  logic [ACC_W-1:0]  shifted;
  logic [CNT_W-1:0]  total;
  logic [2:0]        rem;
  logic [NB_W-1:0]   nb;
  logic [7:0]        rem_mask;
  logic [7:0]        flush_byte;

  assign accept = in_valid && !q_full;

  always_comb begin
    cnt_sat    = (in_data.bit_count > CNT_W'(FIELD_WIDTH)) ? CNT_W'(FIELD_WIDTH)
                                                           : in_data.bit_count;
    mask_w     = (33'd1 << cnt_sat) - 33'd1;
    vmask      = in_data.value & mask_w[31:0];
    // old pending bits on top, new field below
    combined   = ({{FIELD_WIDTH{1'b0}}, pending_r} << cnt_sat)
               | {{PEND_W{1'b0}}, vmask};
    total      = {{(CNT_W-PCNT_W){1'b0}}, pcount_r} + cnt_sat;
    rem        = total[2:0];
    nb         = total[CNT_W-1:3];
    shifted    = combined >> rem;
    rem_mask   = (8'd1 << rem) - 8'd1;
    flush_byte = {pending_r, 1'b0} << (3'd7 - pcount_r);

    pending_nxt = pending_r;
    pcount_nxt  = pcount_r;
    wr_en       = 1'b0;
    wr_entry    = '0;

    if (accept) begin
      if (in_data.command == CMD_FLUSH) begin
        pending_nxt        = '0;
        pcount_nxt         = '0;
        wr_en              = (pcount_r != '0);
        wr_entry.word      = {24'd0, flush_byte};
        wr_entry.nbytes    = NB_W'(1);
        wr_entry.tail_used = {1'b0, pcount_r};
      end else begin
        pending_nxt        = combined[PEND_W-1:0] & rem_mask[PEND_W-1:0];
        pcount_nxt         = rem;
        wr_en              = (nb != '0);
        wr_entry.word      = shifted[31:0];
        wr_entry.nbytes    = nb;
        wr_entry.tail_used = 4'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      pcount_r  <= '0;
    end else begin
      pending_r <= pending_nxt;
      pcount_r  <= pcount_nxt;
    end
  end

endmodule

/* hdl/mfbp_queue.sv */
// four-entry job queue between front and back
`timescale 1ns / 1ps

module mfbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  mfbp_pkg::mfbp_entry_t wr_entry,
  input  logic                  rd_en,
  output mfbp_pkg::mfbp_entry_t rd_entry,
  output logic                  full,
  output logic                  empty
);
  import mfbp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  mfbp_entry_t          slots_r [DEPTH];
  logic [PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [PTR_W-1:0]     rptr_r, rptr_nxt;
  logic [PTR_W:0]       count_r, count_nxt;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr_en) wptr_nxt = wptr_r + PTR_W'(1);
    if (rd_en) rptr_nxt = rptr_r + PTR_W'(1);
    if (wr_en && !rd_en) count_nxt = count_r + (PTR_W+1)'(1);
    else if (rd_en && !wr_en) count_nxt = count_r - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots_r[wptr_r] <= wr_entry;
  end

endmodule

/* hdl/mfbp_back.sv */
// back end: serializes queued jobs into bytes behind an output register
`timescale 1ns / 1ps
`include "msb_first_bit_packer_unit_macros.svh"

module mfbp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mfbp_pkg::mfbp_entry_t rd_entry,
  input  logic                  empty,
  output logic                  rd_en,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mfbp_pkg::mfbp_out_t   out_data
);
  import mfbp_pkg::*;

  logic [31:0]      word_r, word_nxt;
  logic [NB_W-1:0]  left_r, left_nxt;
  logic [3:0]       used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  mfbp_out_t        out_r, out_nxt;

  logic             out_free;
  logic             emit;
  logic             cur_done;
  logic [1:0]       sel;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    emit     = out_free && (left_r != '0);
    // current job is spent, or spends its tail byte this cycle
    cur_done = (left_r == '0) || (emit && (left_r == NB_W'(1)));
    rd_en    = cur_done && !empty;
    sel      = left_r[1:0] - 2'd1;

    word_nxt      = word_r;
    left_nxt      = left_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_nxt.data_byte = word_r[{sel, 3'b000} +: 8];
      out_nxt.last      = (left_r == NB_W'(1));
      out_nxt.used_bits = (left_r == NB_W'(1)) ? used_r : 4'd8;
      left_nxt          = left_r - NB_W'(1);
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (rd_en) begin
      word_nxt = rd_entry.word;
      left_nxt = rd_entry.nbytes;
      used_nxt = rd_entry.tail_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    used_r <= used_nxt;
    out_r  <= out_nxt;
  end

  `MFBP_ASSERT_IMP(a_left_range, clk, rst_n, 1'b1, left_r <= NB_W'(MAX_BYTES), "job byte count out of range")
  `MFBP_ASSERT_IMP(a_partial_is_last, clk, rst_n, out_valid_r && (out_r.used_bits != 4'd8), out_r.last && (out_r.used_bits != 4'd0), "partial byte not marked last")
  `MFBP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, rd_en, !empty, "pop from empty queue")
  `MFBP_ASSERT_NXT(a_emit_shows, clk, rst_n, emit, out_valid_r, "emitted byte not presented")

endmodule

/* hdl/msb_first_bit_packer_unit.sv */
// msb-first bit packer top level
//
// input channel (in_valid/in_stall/in_data): a push appends the low bit_count
// bits of value (counts above 32 saturate), a flush emits the pending
// partial byte zero padded at the bottom and clears it
// result channel (out_valid/out_stall/out_data): one byte per transfer,
// first bit in bit 7, used_bits 8 for full bytes, 1..7 for a flushed byte,
// last set on the final byte an item causes; items that complete no byte
// give no transfer
// first byte of an item passes the job queue, job registers and output register
// throughput: one input item per cycle while the 4-entry job queue has
// room; the output side drains one byte per cycle while not stalled, so a
// push completing n bytes gives n output transfers (up to 4 for a 32-bit push)
// in_stall rises only when the job queue is full; out_stall freezes a valid
// output byte in its register and backs up the queue, then the input
// reset (rst_n low, synchronous) clears the pending bits, empties the
// queue and drops out_valid; no clearing pass is needed
`timescale 1ns / 1ps

module msb_first_bit_packer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfbp_pkg::mfbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfbp_pkg::mfbp_out_t out_data
);
  import mfbp_pkg::*;

  logic        wr_en;
  logic        rd_en;
  logic        q_full;
  logic        q_empty;
  mfbp_entry_t wr_entry;
  mfbp_entry_t rd_entry;

  assign in_stall = q_full;

  mfbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  mfbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  mfbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_entry  (rd_entry),
    .empty     (q_empty),
    .rd_en     (rd_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
